// ===== rtl/core/wcp_pkg.sv =====
// Shared types and constants of the WAV chunk parser.
package wcp_pkg;

	localparam int unsigned FL_W   = 31;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ST_W   = 3;

	// Closing status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_WAV   = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_LEN   = 3'd2;
	localparam logic [ST_W-1:0] ST_FMT_SHORT = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_FMT   = 3'd4;
	localparam logic [ST_W-1:0] ST_NO_DATA   = 3'd5;

	// Input kinds carried on tuser
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_BYTE  = 1'b1;

	// One result item
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              done_res;
		logic [ST_W-1:0]   status;
	} wcp_result_t;

	// Result handed from the parser to the queue
	typedef struct packed {
		logic        valid;
		wcp_result_t res;
	} wcp_push_t;

endpackage

// ===== rtl/core/wav_chunk_parser_core.sv =====
// Top level of the streaming RIFF/WAV chunk parser.
// Takes one item per clock on the slave stream: tuser 0 starts a new file, tuser 1 carries
// the next file byte in tdata. The parser updates its whole state combinationally (two 33-bit
// adds and compares against the file length), and any result goes into a QUEUE_DEPTH-entry
// queue that feeds the master stream, so input is taken every cycle while the queue has room.
// A result is registered in the queue and reaches the master stream in the cycle after its
// item at the earliest. A parse ends in at most one item with tlast set carrying the status
// in tdata (a restart mid-file gives none); data chunk bytes arrive with tuser set.
// Write the file length on the cfg channel while the block is idle, before the start item.
module wav_chunk_parser_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [wcp_pkg::FL_W-1:0] cfg_data,       // file_length
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,   // [7:0] in_byte
	input  logic                     s_axis_tuser,   // [0] func
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [15:0]              m_axis_tdata,   // [7:0] out_byte, [10:8] status, zeros
	output logic                     m_axis_tuser,   // [0] byte_valid
	output logic                     m_axis_tlast    // done_res
);

	logic [wcp_pkg::FL_W-1:0] file_length_q;
	wcp_pkg::wcp_push_t       push;
	wcp_pkg::wcp_result_t     out_res;
	logic                     room;

	// Hold the file length register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			file_length_q <= cfg_data;
		end
	end

	wcp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_length (file_length_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_func     (s_axis_tuser),
		.in_byte     (s_axis_tdata),
		.room        (room),
		.push        (push)
	);

	wcp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the result item onto the master stream
	assign m_axis_tdata = {5'd0, out_res.status, out_res.out_byte};
	assign m_axis_tuser = out_res.byte_valid;
	assign m_axis_tlast = out_res.done_res;

endmodule

// ===== rtl/core/wcp_front.sv =====
// Parser front end: accepts items, walks the RIFF/WAV structure, emits results.
module wcp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [wcp_pkg::FL_W-1:0]   file_length,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_func,
	input  logic [wcp_pkg::BYTE_W-1:0] in_byte,
	input  logic                       room,
	output wcp_pkg::wcp_push_t         push
);

	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_RIFF = 3'd1;
	localparam logic [2:0] PH_HDR  = 3'd2;
	localparam logic [2:0] PH_BODY = 3'd3;
	localparam logic [2:0] PH_PAD  = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_FMT   = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [4:0] IDX_MAX = 5'h1f;

	logic [2:0]  phase_q,   phase_d;
	logic [31:0] bpos_q,    bpos_d;
	logic [4:0]  idx_q,     idx_d;
	logic [31:0] tag_q,     tag_d;
	logic [31:0] len_q,     len_d;
	logic [31:0] rem_q,     rem_d;
	logic [1:0]  kind_q,    kind_d;
	logic [47:0] fmt_q,     fmt_d;
	logic        fok_q,     fok_d;

	logic        accept;
	logic [31:0] tag_new;
	logic [31:0] len_full;
	logic [4:0]  idx_inc;
	logic        pad_sel;
	logic        ap_over;
	logic        hdr_over;
	logic        body_last;
	logic [1:0]  kind_new;

	assign in_ready = room;
	assign accept   = in_valid && in_ready;
	assign tag_new  = {tag_q[23:0], in_byte};
	assign len_full = {in_byte, len_q[23:0]};
	assign idx_inc  = (idx_q == IDX_MAX) ? idx_q : idx_q + 5'd1;
	assign body_last = (rem_q == 32'd1);

	// Room check after a part ends: position + pad + 8 past the file length
	assign pad_sel = (phase_q == PH_BODY) ? len_q[0] : 1'b0;
	assign ap_over = ({1'b0, bpos_q} + 33'd9 + {32'd0, pad_sel}) > {2'b00, file_length};

	// Chunk size check at the end of a header
	assign hdr_over = ({1'b0, bpos_q} + 33'd1 + {1'b0, len_full}) > {2'b00, file_length};

	assign kind_new = (tag_q == TAG_FMT)  ? KIND_FMT :
	                  (tag_q == TAG_DATA) ? KIND_DATA : KIND_OTHER;

	// Next parse state and result
	always_comb begin
		phase_d = phase_q;
		bpos_d  = bpos_q;
		idx_d   = idx_q;
		tag_d   = tag_q;
		len_d   = len_q;
		rem_d   = rem_q;
		kind_d  = kind_q;
		fmt_d   = fmt_q;
		fok_d   = fok_q;
		push    = '0;
		if (accept) begin
			if (in_func == wcp_pkg::FUNC_START) begin
				bpos_d = '0;
				idx_d  = '0;
				tag_d  = '0;
				len_d  = '0;
				kind_d = KIND_OTHER;
				fmt_d  = '0;
				fok_d  = 1'b0;
				if (file_length < 31'd12) begin
					phase_d = PH_DONE;
					push.valid = 1'b1;
					push.res.done_res = 1'b1;
					push.res.status = wcp_pkg::ST_NOT_WAV;
				end else begin
					phase_d = PH_RIFF;
				end
			end else if (phase_q != PH_WAIT && phase_q != PH_DONE) begin
				bpos_d = bpos_q + 32'd1;
				idx_d  = idx_inc;
				case (phase_q)
					PH_RIFF: begin
						if (idx_q < 5'd4 || (idx_q >= 5'd8 && idx_q < 5'd12))
							tag_d = tag_new;
						if ((idx_q == 5'd3 && tag_new != TAG_RIFF) ||
						    (idx_q == 5'd11 && tag_new != TAG_WAVE)) begin
							phase_d = PH_DONE;
							push.valid = 1'b1;
							push.res.done_res = 1'b1;
							push.res.status = wcp_pkg::ST_NOT_WAV;
						end else if (idx_q == 5'd11) begin
							idx_d = '0;
							if (ap_over) begin
								phase_d = PH_DONE;
								push.valid = 1'b1;
								push.res.done_res = 1'b1;
								push.res.status = wcp_pkg::ST_NO_DATA;
							end else begin
								phase_d = PH_HDR;
							end
						end
					end
					PH_HDR: begin
						// Tag bytes first, then the little-endian size
						if (idx_q == 5'd0) begin
							tag_d = {24'd0, in_byte};
							len_d = '0;
						end else if (idx_q < 5'd4) begin
							tag_d = tag_new;
						end else begin
							len_d = len_q | ({24'd0, in_byte} << {idx_q[1:0], 3'b000});
						end
						if (idx_q == 5'd7) begin
							kind_d = kind_new;
							idx_d  = '0;
							rem_d  = len_full;
							if (hdr_over) begin
								phase_d = PH_DONE;
								push.valid = 1'b1;
								push.res.done_res = 1'b1;
								push.res.status = wcp_pkg::ST_BAD_LEN;
							end else if (kind_new == KIND_FMT) begin
								if (len_full < 32'd16) begin
									phase_d = PH_DONE;
									push.valid = 1'b1;
									push.res.done_res = 1'b1;
									push.res.status = wcp_pkg::ST_FMT_SHORT;
								end else begin
									fmt_d   = '0;
									phase_d = PH_BODY;
								end
							end else if (kind_new == KIND_DATA) begin
								if (!fok_q) begin
									phase_d = PH_DONE;
									push.valid = 1'b1;
									push.res.done_res = 1'b1;
									push.res.status = wcp_pkg::ST_BAD_FMT;
								end else if (len_full == 32'd0) begin
									phase_d = PH_DONE;
									push.valid = 1'b1;
									push.res.done_res = 1'b1;
									push.res.status = wcp_pkg::ST_OK;
								end else begin
									phase_d = PH_BODY;
								end
							end else if (len_full == 32'd0) begin
								if (ap_over) begin
									phase_d = PH_DONE;
									push.valid = 1'b1;
									push.res.done_res = 1'b1;
									push.res.status = wcp_pkg::ST_NO_DATA;
								end
							end else begin
								phase_d = PH_BODY;
							end
						end
					end
					PH_BODY: begin
						rem_d = rem_q - 32'd1;
						if (kind_q == KIND_DATA) begin
							// Pass the payload byte through
							push.valid = 1'b1;
							push.res.out_byte = in_byte;
							push.res.byte_valid = 1'b1;
							push.res.done_res = body_last;
							push.res.status = wcp_pkg::ST_OK;
							if (body_last)
								phase_d = PH_DONE;
						end else begin
							if (kind_q == KIND_FMT) begin
								if (idx_q < 5'd4)
									fmt_d[{idx_q[1:0], 3'b000} +: 8] = in_byte;
								else if (idx_q == 5'd14)
									fmt_d[39:32] = in_byte;
								else if (idx_q == 5'd15)
									fmt_d[47:40] = in_byte;
							end
							if (body_last) begin
								if (kind_q == KIND_FMT)
									fok_d = (fmt_d[15:0] == 16'd1) && (fmt_d[31:16] == 16'd1) &&
									        (fmt_d[47:32] == 16'd16);
								idx_d = '0;
								if (ap_over) begin
									phase_d = PH_DONE;
									push.valid = 1'b1;
									push.res.done_res = 1'b1;
									push.res.status = wcp_pkg::ST_NO_DATA;
								end else begin
									phase_d = len_q[0] ? PH_PAD : PH_HDR;
								end
							end
						end
					end
					PH_PAD: begin
						phase_d = PH_HDR;
						idx_d   = '0;
					end
					default: begin
						phase_d = PH_DONE;
					end
				endcase
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			bpos_q  <= '0;
			idx_q   <= '0;
			kind_q  <= KIND_OTHER;
			fok_q   <= 1'b0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_d;
			bpos_q  <= bpos_d;
			idx_q   <= idx_d;
			kind_q  <= kind_d;
			fok_q   <= fok_d;
			rem_q   <= rem_d;
		end
	end

	// Tag, size and format fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			len_q <= '0;
			fmt_q <= '0;
		end else begin
			tag_q <= tag_d;
			len_q <= len_d;
			fmt_q <= fmt_d;
		end
	end

	a_payload_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.res.byte_valid |-> phase_q == PH_BODY && kind_q == KIND_DATA)
		else $error("payload byte outside a data chunk body");

	a_close_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.res.done_res |=> phase_q == PH_DONE)
		else $error("closing result did not end the parse");

	a_start_riff: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_func == wcp_pkg::FUNC_START && file_length >= 31'd12
		|=> phase_q == PH_RIFF && bpos_q == 32'd0)
		else $error("start item did not restart the parse");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> accept)
		else $error("result without an accepted item");

endmodule

// ===== rtl/core/wcp_queue.sv =====
// Result queue between the parser and the output channel.
module wcp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wcp_pkg::wcp_push_t   push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wcp_pkg::wcp_result_t out_res
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	wcp_pkg::wcp_result_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign room      = (count_q != CNT_FULL);
	assign out_valid = (count_q != '0);
	assign out_res   = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Store incoming results
	always_ff @(posedge clk) begin
		if (push.valid)
			entry_q[wr_ptr_q] <= push.res;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (push.valid && !pop)
				count_q <= count_q + CNT_ONE;
			else if (pop && !push.valid)
				count_q <= count_q - CNT_ONE;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue occupancy out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> room)
		else $error("push into a full queue");

endmodule

// ===== dv/testbench.sv =====
// Self-checking stream testbench for the WAV chunk parser core.
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned QUIET_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned SHAPE_COUNT  = 10;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	typedef enum logic [2:0] {P_WAIT, P_RIFF, P_HDR, P_BODY, P_PAD, P_DONE} parse_phase_t;
	typedef enum logic [1:0] {K_OTHER, K_FMT, K_DATA} chunk_kind_t;
	typedef enum int unsigned {SPOIL_NONE, SPOIL_FORMAT, SPOIL_CHANNELS, SPOIL_BITS} fmt_spoil_t;
	typedef enum int unsigned {
		F_GOOD, F_EMPTY_DATA, F_BAD_LEN, F_FMT_SHORT, F_BAD_FMT,
		F_TWO_FMT, F_NO_DATA, F_BAD_TAG, F_RESTART, F_NOISE
	} file_shape_t;

	logic                     clk;
	logic                     arst_n        = 1'b0;
	logic                     cfg_valid     = 1'b0;
	logic                     cfg_ready;
	logic [wcp_pkg::FL_W-1:0] cfg_data      = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [7:0]               s_axis_tdata  = '0;   // [7:0] in_byte
	logic                     s_axis_tuser  = 1'b0; // [0] func
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [15:0]              m_axis_tdata;         // [7:0] out_byte, [10:8] status, zeros
	logic                     m_axis_tuser;         // [0] byte_valid
	logic                     m_axis_tlast;         // done_res

	wav_chunk_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Parser state as the testbench sees it
	logic [wcp_pkg::FL_W-1:0] length_reg;
	parse_phase_t             phase_now;
	logic [31:0]              byte_pos;
	logic [31:0]              part_pos;
	logic [31:0]              tag_window;
	logic [31:0]              chunk_len;
	chunk_kind_t              kind_now;
	logic [47:0]              fmt_word;
	logic                     fmt_good;

	wcp_pkg::wcp_result_t     results_due[$];
	logic [7:0]               file_bytes[$];
	int unsigned              fail_count = 0;
	int unsigned              sent_items = 0;
	bit                       no_idle    = 1'b0;
	bit                       hold_req   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic void clear_parse();
		byte_pos   = '0;
		part_pos   = '0;
		tag_window = '0;
		chunk_len  = '0;
		kind_now   = K_OTHER;
		fmt_word   = '0;
		fmt_good   = 1'b0;
	endfunction

	function automatic bit close_parse(input logic [wcp_pkg::ST_W-1:0] st,
			output wcp_pkg::wcp_result_t res);
		phase_now    = P_DONE;
		res          = '0;
		res.done_res = 1'b1;
		res.status   = st;
		return 1'b1;
	endfunction

	// Decide what follows a chunk or the RIFF header ending at byte_pos
	function automatic bit chunk_end(input logic pad, output wcp_pkg::wcp_result_t res);
		res      = '0;
		part_pos = '0;
		if ({2'b0, byte_pos} + pad + 34'd8 > {3'b0, length_reg})
			return close_parse(wcp_pkg::ST_NO_DATA, res);
		phase_now = pad ? P_PAD : P_HDR;
		return 1'b0;
	endfunction

	// Advance the parse by one item; return 1 when it yields a result item
	function automatic bit parse_wav_item(input logic func, input logic [7:0] b,
			output wcp_pkg::wcp_result_t res);
		logic [31:0] k;
		res = '0;
		if (func == wcp_pkg::FUNC_START) begin
			clear_parse();
			if (length_reg < 12)
				return close_parse(wcp_pkg::ST_NOT_WAV, res);
			phase_now = P_RIFF;
			return 1'b0;
		end
		if (phase_now == P_WAIT || phase_now == P_DONE)
			return 1'b0;
		byte_pos = byte_pos + 1;
		k        = part_pos;
		part_pos = part_pos + 1;
		case (phase_now)
			P_RIFF: begin
				if (k < 4 || (k >= 8 && k < 12))
					tag_window = {tag_window[23:0], b};
				if (k == 3 && tag_window != TAG_RIFF)
					return close_parse(wcp_pkg::ST_NOT_WAV, res);
				if (k == 11) begin
					if (tag_window != TAG_WAVE)
						return close_parse(wcp_pkg::ST_NOT_WAV, res);
					return chunk_end(1'b0, res);
				end
				return 1'b0;
			end
			P_HDR: begin
				if (k == 0) begin
					tag_window = '0;
					chunk_len  = '0;
				end
				if (k < 4)
					tag_window = {tag_window[23:0], b};
				else
					chunk_len = chunk_len | ({24'b0, b} << (8 * k[1:0]));
				if (k < 7)
					return 1'b0;
				kind_now = (tag_window == TAG_FMT) ? K_FMT :
					(tag_window == TAG_DATA) ? K_DATA : K_OTHER;
				part_pos = '0;
				if ({1'b0, byte_pos} + {1'b0, chunk_len} > {2'b0, length_reg})
					return close_parse(wcp_pkg::ST_BAD_LEN, res);
				if (kind_now == K_FMT) begin
					if (chunk_len < 16)
						return close_parse(wcp_pkg::ST_FMT_SHORT, res);
					fmt_word  = '0;
					phase_now = P_BODY;
					return 1'b0;
				end
				if (kind_now == K_DATA) begin
					if (!fmt_good)
						return close_parse(wcp_pkg::ST_BAD_FMT, res);
					if (chunk_len == 0)
						return close_parse(wcp_pkg::ST_OK, res);
					phase_now = P_BODY;
					return 1'b0;
				end
				if (chunk_len == 0)
					return chunk_end(1'b0, res);
				phase_now = P_BODY;
				return 1'b0;
			end
			P_BODY: begin
				// pass payload bytes straight through
				if (kind_now == K_DATA) begin
					res.out_byte   = b;
					res.byte_valid = 1'b1;
					if ({1'b0, k} + 33'd1 >= {1'b0, chunk_len}) begin
						phase_now    = P_DONE;
						res.done_res = 1'b1;
					end
					return 1'b1;
				end
				if (kind_now == K_FMT) begin
					if (k < 4)
						fmt_word[8 * k[1:0] +: 8] = b;
					else if (k == 14 || k == 15)
						fmt_word[32 + 8 * k[0] +: 8] = b;
				end
				if ({1'b0, k} + 33'd1 < {1'b0, chunk_len})
					return 1'b0;
				if (kind_now == K_FMT)
					fmt_good = fmt_word[15:0] == 16'd1 && fmt_word[31:16] == 16'd1
						&& fmt_word[47:32] == 16'd16;
				return chunk_end(chunk_len[0], res);
			end
			P_PAD: begin
				phase_now = P_HDR;
				part_pos  = '0;
				return 1'b0;
			end
			default: begin
				phase_now = P_DONE;
				return 1'b0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	// Offer one item, wait for it to be taken, then record what it should cause
	task automatic send_item(input logic func, input logic [7:0] b);
		wcp_pkg::wcp_result_t res;
		while (!no_idle && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
		if (parse_wav_item(func, b, res))
			results_due.push_back(res);
	endtask

	// Hold the input until every due result has come out, then settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_file_length(input logic [wcp_pkg::FL_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		length_reg = len;
	endtask

	// Stream file_bytes as one file; a nonzero prefix restarts partway through
	task automatic play_file(input logic [wcp_pkg::FL_W-1:0] len, input int unsigned prefix,
			input int unsigned tail);
		drain_results();
		write_file_length(len);
		if (prefix != 0) begin
			send_item(wcp_pkg::FUNC_START, 8'($urandom_range(255)));
			for (int i = 0; i < prefix; i++)
				send_item(wcp_pkg::FUNC_BYTE, file_bytes[i]);
		end
		send_item(wcp_pkg::FUNC_START, 8'($urandom_range(255)));
		foreach (file_bytes[i])
			send_item(wcp_pkg::FUNC_BYTE, file_bytes[i]);
		repeat (tail) send_item(wcp_pkg::FUNC_BYTE, 8'($urandom_range(255)));
	endtask

	// ---------------------------------------------------------------- file building

	task automatic put_tag(input logic [31:0] t);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(t[31 - 8 * i -: 8]);
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(w[8 * i +: 8]);
	endtask

	task automatic put_riff_header();
		put_tag(TAG_RIFF);
		put_word($urandom);
		put_tag(TAG_WAVE);
	endtask

	task automatic put_other(input int unsigned size);
		put_tag($urandom);
		put_word(size);
		repeat (size + size % 2) file_bytes.push_back(8'($urandom_range(255)));
	endtask

	function automatic logic [15:0] spoiled(input logic [15:0] good);
		logic [15:0] v;
		if ($urandom_range(1))
			return good ^ (16'd1 << $urandom_range(15));
		v = 16'($urandom_range(65535));
		return (v == good) ? ~v : v;
	endfunction

	task automatic put_fmt(input int unsigned size, input fmt_spoil_t spoil);
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [15:0] depth;
		logic [7:0]  body[16];
		fmt_code = 16'd1;
		chans    = 16'd1;
		depth    = 16'd16;
		case (spoil)
			SPOIL_FORMAT:   fmt_code = spoiled(fmt_code);
			SPOIL_CHANNELS: chans    = spoiled(chans);
			SPOIL_BITS:     depth    = spoiled(depth);
			default: ;
		endcase
		body[0] = fmt_code[7:0];
		body[1] = fmt_code[15:8];
		body[2] = chans[7:0];
		body[3] = chans[15:8];
		for (int i = 4; i < 14; i++)
			body[i] = 8'($urandom_range(255));
		body[14] = depth[7:0];
		body[15] = depth[15:8];
		put_tag(TAG_FMT);
		put_word(size);
		for (int i = 0; i < size; i++)
			file_bytes.push_back(i < 16 ? body[i] : 8'($urandom_range(255)));
		if (size % 2)
			file_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic put_data(input int unsigned count, input logic [31:0] declared);
		put_tag(TAG_DATA);
		put_word(declared);
		repeat (count) file_bytes.push_back(8'($urandom_range(255)));
	endtask

	// Build one file of the given shape with random content
	task automatic build_file(input file_shape_t shape, output logic [wcp_pkg::FL_W-1:0] len,
			output int unsigned prefix);
		int unsigned data_n;
		file_bytes.delete();
		prefix = 0;
		if (shape == F_NOISE) begin
			repeat ($urandom_range(12, 40)) file_bytes.push_back(8'($urandom_range(255)));
			len = wcp_pkg::FL_W'($urandom_range(0, 60));
			return;
		end
		put_riff_header();
		if (shape == F_BAD_TAG)
			file_bytes[8 * $urandom_range(1) + $urandom_range(3)] ^= 8'd1 << $urandom_range(7);
		if (shape == F_NO_DATA && $urandom_range(3) == 0) begin
			len = wcp_pkg::FL_W'(12 + $urandom_range(7));
			return;
		end
		if ($urandom_range(2) == 0)
			put_other($urandom_range(9));
		case (shape)
			F_FMT_SHORT: put_fmt($urandom_range(15), SPOIL_NONE);
			F_BAD_FMT: begin
				if ($urandom_range(1))
					put_fmt(16, fmt_spoil_t'($urandom_range(1, 3)));
			end
			F_TWO_FMT: begin
				// the later fmt chunk decides
				if ($urandom_range(1)) begin
					put_fmt(16, fmt_spoil_t'($urandom_range(1, 3)));
					put_fmt(16 + $urandom_range(3), SPOIL_NONE);
				end else begin
					put_fmt(16 + $urandom_range(3), SPOIL_NONE);
					put_fmt(16, fmt_spoil_t'($urandom_range(1, 3)));
				end
			end
			default: put_fmt(16 + $urandom_range(3), SPOIL_NONE);
		endcase
		if ($urandom_range(2) == 0)
			put_other($urandom_range(9));
		data_n = (shape == F_EMPTY_DATA) ? 0 : $urandom_range(1, 40);
		case (shape)
			F_NO_DATA: begin
				put_other(2 * $urandom_range(4) + 1);
				if ($urandom_range(1)) begin
					// leave off the final pad byte
					void'(file_bytes.pop_back());
					len = wcp_pkg::FL_W'(file_bytes.size());
				end else begin
					len = wcp_pkg::FL_W'(file_bytes.size() + $urandom_range(7));
				end
			end
			F_BAD_LEN: begin
				if ($urandom_range(2) == 0) begin
					put_data(0, 32'h8000_0000 | $urandom);
					len = {wcp_pkg::FL_W{1'b1}};
				end else begin
					put_data(data_n, data_n);
					len = wcp_pkg::FL_W'(file_bytes.size() - $urandom_range(1, data_n));
				end
			end
			default: begin
				put_data(data_n, data_n);
				len = wcp_pkg::FL_W'(file_bytes.size());
				if (shape == F_GOOD && $urandom_range(3) == 0)
					len = {wcp_pkg::FL_W{1'b1}};
				if (shape == F_RESTART)
					prefix = $urandom_range(1, file_bytes.size() - 1);
			end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_idle_bytes();
		send_item(wcp_pkg::FUNC_BYTE, 8'h00);
		send_item(wcp_pkg::FUNC_BYTE, 8'hFF);
	endtask

	task automatic test_short_files();
		file_bytes.delete();
		play_file('0, 0, 1);
		play_file(wcp_pkg::FL_W'(11), 0, 0);
	endtask

	task automatic test_bad_tags();
		file_bytes.delete();
		put_tag(TAG_RIFF ^ 32'h0000_0001);
		play_file(wcp_pkg::FL_W'(12), 0, 0);
		file_bytes.delete();
		put_riff_header();
		file_bytes[11] ^= 8'h80;
		play_file(wcp_pkg::FL_W'(12), 0, 0);
	endtask

	task automatic test_steady_stream();
		file_bytes.delete();
		put_riff_header();
		put_fmt(16, SPOIL_NONE);
		put_data(96, 96);
		no_idle = 1'b1;
		play_file(wcp_pkg::FL_W'(file_bytes.size()), 0, 0);
		drain_results();
		no_idle = 1'b0;
	endtask

	task automatic test_output_stall();
		file_bytes.delete();
		put_riff_header();
		put_fmt(18, SPOIL_NONE);
		put_data(48, 48);
		drain_results();
		hold_req = 1'b1;
		play_file(wcp_pkg::FL_W'(file_bytes.size()), 0, 0);
	endtask

	task automatic test_random_files();
		int unsigned              target;
		int unsigned              file_no;
		logic [wcp_pkg::FL_W-1:0] len;
		int unsigned              prefix;
		target  = sent_items + RANDOM_ITEMS;
		file_no = 0;
		while (sent_items < target) begin
			build_file(file_shape_t'(file_no % SHAPE_COUNT), len, prefix);
			play_file(len, prefix, $urandom_range(3));
			file_no++;
		end
	endtask

	// ---------------------------------------------------------------- result side

	// Drive the result ready; honor a requested hold-off
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result item with the oldest one due
	initial begin : result_check
		wcp_pkg::wcp_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					$error("result item with none due: tdata %h tuser %b tlast %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
					check_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tuser));
					check_field("done_res", 8'(want.done_res), 8'(m_axis_tlast));
					check_field("status", 8'(want.status), 8'(m_axis_tdata[10:8]));
				end
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("FAIL wav_chunk_parser_core");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : main
		length_reg = '0;
		phase_now  = P_WAIT;
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_short_files();
		test_bad_tags();
		test_steady_stream();
		test_output_stall();
		test_random_files();
		drain_results();
		if (fail_count == 0 && results_due.size() == 0)
			$display("PASS wav_chunk_parser_core");
		else
			$display("FAIL wav_chunk_parser_core");
		$finish;
	end

endmodule
